@@ src/bcsh_pkg.sv @@
// Shared types, constants and the record builder for the bitrate code sector histogram.
// Used by the core, the result queue and the top level.
package bcsh_pkg;

	localparam int CODE_COUNT  = 6;
	localparam int CNT_W       = 14;
	localparam int WSUM_W      = 16;
	localparam int TRACK_BYTES = 8192;
	localparam int CNT_LIMIT   = (1 << CNT_W) - 1;

	localparam logic [CNT_W-1:0]  CNT_CAP  =
		CNT_W'((TRACK_BYTES < CNT_LIMIT) ? TRACK_BYTES : CNT_LIMIT);
	localparam logic [WSUM_W-1:0] WSUM_CAP = '1;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE  = 8'h55;

	localparam logic KIND_SECTOR = 1'b0;
	localparam logic KIND_TRACK  = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// accumulator widths for six counts and their weighted sum (weights 1..6)
	localparam int SUM_ACC_W  = CNT_W + 3;
	localparam int WSUM_ACC_W = CNT_W + 5;

	typedef logic [CODE_COUNT-1:0][CNT_W-1:0] cnt_arr_t;

	typedef struct packed {
		logic              kind;
		cnt_arr_t          counts;
		logic [CNT_W-1:0]  byte_total;
		logic [WSUM_W-1:0] weighted_total;
		logic [CNT_W-1:0]  sync_count;
		logic              bad;
		logic              run_end;
	} rec_t;

	typedef struct packed {
		logic [1:0] num;
		rec_t       rec0;
		rec_t       rec1;
	} push_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, CNT_CAP}) ? CNT_CAP : s[CNT_W-1:0];
	endfunction

	function automatic rec_t make_record(input logic kind, input cnt_arr_t cnt,
			input logic [CNT_W-1:0] syncs, input logic bad, input logic run_end);
		logic [SUM_ACC_W-1:0]  sum;
		logic [WSUM_ACC_W-1:0] wsum;
		rec_t                  r;
		sum  = '0;
		wsum = '0;
		for (int m = 0; m < CODE_COUNT; m++) begin
			sum  = sum + SUM_ACC_W'(cnt[m]);
			wsum = wsum + WSUM_ACC_W'(cnt[m]) * WSUM_ACC_W'(m + 1);
		end
		r.kind           = kind;
		r.counts         = cnt;
		r.byte_total     = (sum > SUM_ACC_W'(CNT_CAP)) ? CNT_CAP : sum[CNT_W-1:0];
		r.weighted_total = (wsum > WSUM_ACC_W'(WSUM_CAP)) ? WSUM_CAP : wsum[WSUM_W-1:0];
		r.sync_count     = syncs;
		r.bad            = bad;
		r.run_end        = run_end;
		return r;
	endfunction

endpackage

@@ src/bcsh_in_if.sv @@
// Input channel: one dump byte per request, with its last-byte mark.
// Standalone; no package needed.
interface bcsh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       final_byte;

	modport source(output valid, code_byte, final_byte, input ready);
	modport sink(input valid, code_byte, final_byte, output ready);
endinterface

@@ src/bcsh_out_if.sv @@
// Output channel: one sector record or track summary per request.
// Standalone; no package needed.
interface bcsh_out_if;
	logic        valid;
	logic        ready;
	logic        record_kind;
	logic [13:0] count_code0;
	logic [13:0] count_code1;
	logic [13:0] count_code2;
	logic [13:0] count_code3;
	logic [13:0] count_code4;
	logic [13:0] count_code5;
	logic [13:0] byte_total;
	logic [15:0] weighted_total;
	logic [13:0] sync_count;
	logic        bad_code_seen;
	logic        run_end;

	modport source(output valid, record_kind, count_code0, count_code1, count_code2,
		count_code3, count_code4, count_code5, byte_total, weighted_total, sync_count,
		bad_code_seen, run_end, input ready);
	modport sink(input valid, record_kind, count_code0, count_code1, count_code2,
		count_code3, count_code4, count_code5, byte_total, weighted_total, sync_count,
		bad_code_seen, run_end, output ready);
endinterface

@@ src/bcsh_core.sv @@
// Input register, histogram state and record generation.
// Depends on bcsh_pkg and bcsh_in_if; pushes up to two records per byte.
module bcsh_core (
	input  logic            clk,
	input  logic            arst_n,
	bcsh_in_if.sink         byte_ch,
	input  logic            room,
	output bcsh_pkg::push_t push
);
	import bcsh_pkg::*;

	logic             s1_valid_q;
	logic [7:0]       s1_byte_s1;
	logic             s1_final_s1;
	cnt_arr_t         sector_q;
	cnt_arr_t         track_q;
	logic [CNT_W-1:0] syncs_q;
	logic             finished_q;
	logic             bad_q;

	logic             process;
	logic             accept;
	logic             is_code;
	logic             is_sync;
	logic             is_end;
	logic             is_bad;
	logic             closes;
	logic [CNT_W-1:0] syncs_n;
	logic             bad_n;
	cnt_arr_t         sector_n;
	cnt_arr_t         track_n;
	rec_t             sect_rec;
	rec_t             sum_rec;

	// queue room is taken from a registered count, so ready never waits on the sink
	assign process       = s1_valid_q && room;
	assign byte_ch.ready = !s1_valid_q || process;
	assign accept        = byte_ch.valid && byte_ch.ready;

	always_comb begin
		is_code = s1_byte_s1 < 8'(CODE_COUNT);
		is_sync = s1_byte_s1 == SYNC_BYTE;
		is_end  = s1_byte_s1 == END_BYTE;
		is_bad  = !is_code && !is_sync && !is_end;
		closes  = is_end || s1_final_s1;
		syncs_n = is_sync ? sat_add(syncs_q, CNT_W'(1)) : syncs_q;
		bad_n   = bad_q | is_bad;
		for (int m = 0; m < CODE_COUNT; m++) begin
			track_n[m] = is_sync ? sat_add(track_q[m], sector_q[m]) : track_q[m];
			if (is_sync)
				sector_n[m] = '0;
			else if (is_code && s1_byte_s1[2:0] == 3'(m))
				sector_n[m] = sat_add(sector_q[m], CNT_W'(1));
			else
				sector_n[m] = sector_q[m];
		end
		sect_rec = make_record(KIND_SECTOR, sector_q, syncs_n, bad_n, !closes);
		sum_rec  = make_record(KIND_TRACK, track_n, syncs_n, bad_n, 1'b1);

		push.num  = 2'd0;
		push.rec0 = sect_rec;
		push.rec1 = sum_rec;
		if (process && !finished_q) begin
			if (is_sync) begin
				push.num = closes ? 2'd2 : 2'd1;
			end else if (closes) begin
				push.num  = 2'd1;
				push.rec0 = sum_rec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_byte_s1  <= byte_ch.code_byte;
			s1_final_s1 <= byte_ch.final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			sector_q   <= '0;
			track_q    <= '0;
			syncs_q    <= '0;
			finished_q <= 1'b0;
			bad_q      <= 1'b0;
		end else begin
			s1_valid_q <= accept || (s1_valid_q && !process);
			if (process) begin
				if (s1_final_s1) begin
					// last byte of the dump: start a fresh track
					sector_q   <= '0;
					track_q    <= '0;
					syncs_q    <= '0;
					finished_q <= 1'b0;
					bad_q      <= 1'b0;
				end else if (!finished_q) begin
					sector_q   <= sector_n;
					track_q    <= track_n;
					syncs_q    <= syncs_n;
					bad_q      <= bad_n;
					finished_q <= is_end;
				end
			end
		end
	end

endmodule

@@ src/bcsh_fifo.sv @@
// Result queue: takes up to two records a cycle, hands out one per request.
// Depends on bcsh_pkg and bcsh_out_if.
module bcsh_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  bcsh_pkg::push_t push,
	output logic            room,
	bcsh_out_if.source      record_ch
);
	import bcsh_pkg::*;

	rec_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;
	rec_t               head;

	assign room            = count_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign record_ch.valid = count_q != '0;
	assign pop             = record_ch.valid && record_ch.ready;
	assign head            = mem_q[rd_ptr_q];

	assign record_ch.record_kind    = head.kind;
	assign record_ch.count_code0    = head.counts[0];
	assign record_ch.count_code1    = head.counts[1];
	assign record_ch.count_code2    = head.counts[2];
	assign record_ch.count_code3    = head.counts[3];
	assign record_ch.count_code4    = head.counts[4];
	assign record_ch.count_code5    = head.counts[5];
	assign record_ch.byte_total     = head.byte_total;
	assign record_ch.weighted_total = head.weighted_total;
	assign record_ch.sync_count     = head.sync_count;
	assign record_ch.bad_code_seen  = head.bad;
	assign record_ch.run_end        = head.run_end;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0)
			mem_q[wr_ptr_q] <= push.rec0;
		if (push.num == 2'd2)
			mem_q[FIFO_AW'(wr_ptr_q + 1'b1)] <= push.rec1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= FIFO_AW'(wr_ptr_q + FIFO_AW'(push.num));
			if (pop)
				rd_ptr_q <= FIFO_AW'(rd_ptr_q + 1'b1);
			count_q <= FIFO_CW'(count_q + FIFO_CW'(push.num) - FIFO_CW'(pop));
		end
	end

endmodule

@@ src/bitrate_code_sector_histogram.sv @@
// Bitrate code histogram over a track dump, one byte per request on byte_ch. Each accepted
// byte lands in an input register and is processed once the queue has room, so a new byte is
// taken every cycle while the queue has room; the records of a byte pass from the input
// register into the queue and are then valid on record_ch. Records wait in a four-entry
// queue; a sync on the last byte produces a sector record and the track summary, two queue
// entries, so a byte held in the input register waits, and byte_ch ready drops, while the
// queue holds more than two records. No clearing pass follows reset.
module bitrate_code_sector_histogram (
	input  logic       clk,
	input  logic       arst_n,
	bcsh_in_if.sink    byte_ch,
	bcsh_out_if.source record_ch
);
	import bcsh_pkg::*;

	push_t push;
	logic  room;

	bcsh_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.room    (room),
		.push    (push)
	);

	bcsh_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.record_ch (record_ch)
	);

endmodule

@@ src/bcsh_chk.sv @@
// Port-level checks for the histogram block, bound to the top level.
// Needs only the top level's channel signals.
module bcsh_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [13:0] byte_total,
	input logic [15:0] weighted_total,
	input logic [13:0] sync_count,
	input logic        run_end
);

	// a stalled record holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_total)
			&& $stable(weighted_total) && $stable(kind))
		else $error("stalled record changed");

	// a summary always ends the requests of its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> run_end)
		else $error("track summary without run_end");

	// weights are at least one, so the weighted total never falls below the byte total
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> weighted_total >= 16'(byte_total))
		else $error("weighted total below byte total");

	// a sector record is caused by a sync, which is already counted
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> sync_count != 14'd0)
		else $error("sector record with zero sync count");

endmodule

bind bitrate_code_sector_histogram bcsh_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (record_ch.valid),
	.out_ready      (record_ch.ready),
	.kind           (record_ch.record_kind),
	.byte_total     (record_ch.byte_total),
	.weighted_total (record_ch.weighted_total),
	.sync_count     (record_ch.sync_count),
	.run_end        (record_ch.run_end)
);
